[src/rcpe_pkg.sv]
// ----------------------------------------------------------------------------
// rcpe_pkg - shared definitions for the rectangle collision pair engine
// Slot table sizing, beat field positions, codes and the slot entry layout.
// ----------------------------------------------------------------------------
package rcpe_pkg;

  // Table and coordinate sizing
  localparam int SLOTS      = 8;                       // 2 .. 8
  localparam int COORD_BITS = 16;                      // 8 .. 16
  localparam int SLOT_W     = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int SIZE_W     = COORD_BITS - 1;
  localparam int EXT_W      = COORD_BITS + 2;          // room for edge sums and y+1
  localparam int TYPE_W     = 4;
  localparam int MASK_ROWS  = 4;
  localparam int ROW_W      = 16;

  // Input beat layout (tdata), fixed by the field widths
  localparam int IN_DATA_W   = 72;
  localparam int IN_SLOT_LSB = 0;
  localparam int IN_X_LSB    = 3;
  localparam int IN_Y_LSB    = 19;
  localparam int IN_W_LSB    = 35;
  localparam int IN_H_LSB    = 50;
  localparam int IN_TYPE_LSB = 65;
  localparam int IN_LSN_BIT  = 69;

  localparam int OUT_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [2:0] CFG_MASK_0_3   = 3'd0;
  localparam logic [2:0] CFG_MASK_12_15 = 3'd3;
  localparam logic [2:0] CFG_WALL_TYPE  = 3'd4;
  localparam logic [TYPE_W-1:0] WALL_TYPE_RESET = 4'd1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_PASS   = 2'd2,
    ACT_GROUND = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_EVENT  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_GROUND = 2'd2,
    KIND_ACK    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACK,
    ST_FREE,
    ST_PAIR_RD,
    ST_PAIR_CMP,
    ST_EV_IK,
    ST_EV_KI,
    ST_DONE,
    ST_GND_RD,
    ST_GND_CMP,
    ST_GND_OUT
  } state_t;

  // One slot entry as held in the table memory
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [SIZE_W-1:0]     w;
    logic        [SIZE_W-1:0]     h;
    logic        [TYPE_W-1:0]     ctype;
    logic                         listen;
  } entry_t;

endpackage

[src/rect_collision_pair_engine.sv]
// ----------------------------------------------------------------------------
// rect_collision_pair_engine - slot table of rectangles with pairwise overlap
// Add, delete, collision pass and ground query over an AABB slot table.
// ----------------------------------------------------------------------------
// The block keeps SLOTS rectangles in a synchronous table memory with two read
// ports; valid and pending-delete marks sit in flip-flops and reset to empty.
// One item is worked on at a time. A ground query reads the hitbox and one
// candidate wall per memory access and compares them in the next cycle. A
// pass frees the pending slots and then walks every slot pair
// (SLOTS*(SLOTS-1)/2 of them): a pair with an empty slot is skipped, a pair
// of valid slots is read and then compared, and each emitted event follows.
// Every result stalls while the output register is held by the consumer, and
// the next item is taken while the last result still waits.
// Each item yields one beat with tlast set; a pass yields its event beats
// (receiver first in tdata) and then a done beat with tlast set.
module rect_collision_pair_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: slot[2:0], rect_x[18:3], rect_y[34:19], rect_w[49:35],
  //        rect_h[64:50], collider_type[68:65], has_listener[69], zero[71:70]
  input  logic [rcpe_pkg::IN_DATA_W-1:0] in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                    in_tuser,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: receiver_slot[2:0], other_slot[5:3], grounded[6], zero[7]
  output logic [rcpe_pkg::OUT_DATA_W-1:0] out_tdata,
  // tuser: kind[1:0]
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [63:0]                   cfg_data
);
  import rcpe_pkg::*;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]    i_r, i_nxt;
  logic [SLOT_W-1:0]    k_r, k_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [SLOTS-1:0]     valid_r, valid_nxt;
  logic [SLOTS-1:0]     pend_r, pend_nxt;
  logic                 hit_r, hit_nxt;
  logic                 ev_ik_r, ev_ik_nxt;
  logic                 ev_ki_r, ev_ki_nxt;

  logic [63:0]          mask_r [MASK_ROWS];
  logic [TYPE_W-1:0]    wall_r;

  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [2:0]           out_recv_r, out_recv_nxt;
  logic [2:0]           out_other_r, out_other_nxt;
  logic                 out_gnd_r, out_gnd_nxt;
  logic                 out_last_r, out_last_nxt;

  // Slot table memory: one write port, two registered read ports
  entry_t               mem [SLOTS];
  logic                 mem_we;
  logic [SLOT_W-1:0]    mem_wa;
  entry_t               mem_wd;
  logic [SLOT_W-1:0]    rd_addr_a, rd_addr_b;
  entry_t               rd_a_r, rd_b_r;

  // --------------------------------------------------------------------------
  // Input beat decode
  // --------------------------------------------------------------------------
  action_t              in_action;
  logic [2:0]           in_slot;
  logic                 in_slot_ok;
  logic [SLOT_W-1:0]    in_idx;
  entry_t               in_entry;
  logic                 in_fire;
  logic                 out_free;

  assign in_action  = action_t'(in_tuser);
  assign in_slot    = in_tdata[IN_SLOT_LSB +: 3];
  assign in_slot_ok = (32'(in_slot) < SLOTS);
  assign in_idx     = in_slot[SLOT_W-1:0];

  assign in_entry.x      = in_tdata[IN_X_LSB +: COORD_BITS];
  assign in_entry.y      = in_tdata[IN_Y_LSB +: COORD_BITS];
  assign in_entry.w      = in_tdata[IN_W_LSB +: SIZE_W];
  assign in_entry.h      = in_tdata[IN_H_LSB +: SIZE_W];
  assign in_entry.ctype  = in_tdata[IN_TYPE_LSB +: TYPE_W];
  assign in_entry.listen = in_tdata[IN_LSN_BIT];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // the output register can take a new beat when empty or draining now
  assign out_free = !out_valid_r || out_tready;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Strict overlap; a_down moves rectangle a one unit lower.
  function automatic logic overlap(entry_t a, entry_t b, logic a_down);
    logic signed [EXT_W-1:0] ax, ay, aw, ah, bx, by, bw, bh;
    ax = EXT_W'(a.x);
    ay = EXT_W'(a.y) + EXT_W'(a_down);
    aw = EXT_W'({1'b0, a.w});
    ah = EXT_W'({1'b0, a.h});
    bx = EXT_W'(b.x);
    by = EXT_W'(b.y);
    bw = EXT_W'({1'b0, b.w});
    bh = EXT_W'({1'b0, b.h});
    return !((by + bh <= ay) || (by >= ay + ah) || (bx + bw <= ax) || (bx >= ax + aw));
  endfunction

  // Mask bit: may a receiver of type r collide with type t
  function automatic logic permits(logic [TYPE_W-1:0] r, logic [TYPE_W-1:0] t);
    logic [63:0] row;
    row = mask_r[r[TYPE_W-1:2]];
    return row[{r[1:0], t}];
  endfunction

  // --------------------------------------------------------------------------
  // Pair walk advance: next (i,k) with i<k, or the end of the walk
  // --------------------------------------------------------------------------
  logic                 adv_done;
  logic [SLOT_W-1:0]    adv_i, adv_k;

  always_comb begin
    adv_done = 1'b0;
    adv_i    = i_r;
    adv_k    = k_r + SLOT_W'(1);
    if (32'(k_r) == SLOTS - 1) begin
      if (32'(i_r) == SLOTS - 2) begin
        adv_done = 1'b1;
        adv_k    = k_r;
      end else begin
        adv_i = i_r + SLOT_W'(1);
        adv_k = i_r + SLOT_W'(2);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Compare on registered read data
  // --------------------------------------------------------------------------
  logic pair_ov, ev_ik_c, ev_ki_c;
  logic gnd_ov, gnd_wall_ok, gnd_hit_c;

  // pass: port A holds slot i, port B holds slot k
  assign pair_ov = overlap(rd_a_r, rd_b_r, 1'b0);
  assign ev_ik_c = pair_ov && rd_a_r.listen && permits(rd_a_r.ctype, rd_b_r.ctype);
  assign ev_ki_c = pair_ov && rd_b_r.listen && permits(rd_b_r.ctype, rd_a_r.ctype);

  // ground: port A holds the hitbox, port B the candidate wall i
  assign gnd_ov      = overlap(rd_a_r, rd_b_r, 1'b1);
  assign gnd_wall_ok = valid_r[i_r] && !pend_r[i_r] && (rd_b_r.ctype == wall_r);
  assign gnd_hit_c   = gnd_ov && gnd_wall_ok &&
                       ((rd_a_r.listen && permits(rd_a_r.ctype, rd_b_r.ctype)) ||
                        (rd_b_r.listen && permits(rd_b_r.ctype, rd_a_r.ctype)));

  // Ground walks wall candidates on port B with the hitbox parked on port A
  always_comb begin
    if (state_r == ST_GND_RD || state_r == ST_GND_CMP) begin
      rd_addr_a = slot_r;
      rd_addr_b = i_r;
    end else begin
      rd_addr_a = i_r;
      rd_addr_b = k_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state, table updates and result beats
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    slot_nxt      = slot_r;
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    ev_ik_nxt     = ev_ik_r;
    ev_ki_nxt     = ev_ki_r;
    mem_we        = 1'b0;
    mem_wa        = in_idx;
    mem_wd        = in_entry;
    // drop the held beat once taken
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_recv_nxt  = out_recv_r;
    out_other_nxt = out_other_r;
    out_gnd_nxt   = out_gnd_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          slot_nxt = in_idx;
          unique case (in_action)
            ACT_ADD: begin
              if (in_slot_ok) begin
                mem_we            = 1'b1;
                valid_nxt[in_idx] = 1'b1;
                pend_nxt[in_idx]  = 1'b0;
              end
              state_nxt = ST_ACK;
            end
            ACT_DELETE: begin
              if (in_slot_ok && valid_r[in_idx]) begin
                pend_nxt[in_idx] = 1'b1;
              end
              state_nxt = ST_ACK;
            end
            ACT_PASS: begin
              state_nxt = ST_FREE;
            end
            ACT_GROUND: begin
              hit_nxt = 1'b0;
              i_nxt   = '0;
              if (in_slot_ok && valid_r[in_idx] && !pend_r[in_idx]) begin
                state_nxt = ST_GND_RD;
              end else begin
                state_nxt = ST_GND_OUT;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_ACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_recv_nxt  = '0;
          out_other_nxt = '0;
          out_gnd_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_FREE: begin
        // free every pending slot, then start the walk at (0,1)
        valid_nxt = valid_r & ~pend_r;
        pend_nxt  = '0;
        i_nxt     = '0;
        k_nxt     = SLOT_W'(1);
        state_nxt = ST_PAIR_RD;
      end

      ST_PAIR_RD: begin
        if (valid_r[i_r] && valid_r[k_r]) begin
          state_nxt = ST_PAIR_CMP;
        end else if (adv_done) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt = adv_i;
          k_nxt = adv_k;
        end
      end

      ST_PAIR_CMP: begin
        ev_ik_nxt = ev_ik_c;
        ev_ki_nxt = ev_ki_c;
        if (ev_ik_c) begin
          state_nxt = ST_EV_IK;
        end else if (ev_ki_c) begin
          state_nxt = ST_EV_KI;
        end else if (adv_done) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = adv_i;
          k_nxt     = adv_k;
          state_nxt = ST_PAIR_RD;
        end
      end

      ST_EV_IK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EVENT;
          out_recv_nxt  = 3'(i_r);
          out_other_nxt = 3'(k_r);
          out_gnd_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          if (ev_ki_r) begin
            state_nxt = ST_EV_KI;
          end else if (adv_done) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt     = adv_i;
            k_nxt     = adv_k;
            state_nxt = ST_PAIR_RD;
          end
        end
      end

      ST_EV_KI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_EVENT;
          out_recv_nxt  = 3'(k_r);
          out_other_nxt = 3'(i_r);
          out_gnd_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          if (adv_done) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt     = adv_i;
            k_nxt     = adv_k;
            state_nxt = ST_PAIR_RD;
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DONE;
          out_recv_nxt  = '0;
          out_other_nxt = '0;
          out_gnd_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_GND_RD: begin
        state_nxt = ST_GND_CMP;
      end

      ST_GND_CMP: begin
        hit_nxt = hit_r || gnd_hit_c;
        if (32'(i_r) == SLOTS - 1) begin
          state_nxt = ST_GND_OUT;
        end else begin
          i_nxt     = i_r + SLOT_W'(1);
          state_nxt = ST_GND_RD;
        end
      end

      ST_GND_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_GROUND;
          out_recv_nxt  = '0;
          out_other_nxt = '0;
          out_gnd_nxt   = hit_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Clocked state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk counters and payload hold their value without reset
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    k_r         <= k_nxt;
    slot_r      <= slot_nxt;
    hit_r       <= hit_nxt;
    ev_ik_r     <= ev_ik_nxt;
    ev_ki_r     <= ev_ki_nxt;
    out_kind_r  <= out_kind_nxt;
    out_recv_r  <= out_recv_nxt;
    out_other_r <= out_other_nxt;
    out_gnd_r   <= out_gnd_nxt;
    out_last_r  <= out_last_nxt;
  end

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MASK_ROWS; r++) begin
        mask_r[r] <= '0;
      end
      wall_r <= WALL_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index <= CFG_MASK_12_15) begin
        mask_r[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index == CFG_WALL_TYPE) begin
        wall_r <= cfg_data[TYPE_W-1:0];
      end
    end
  end

  // slot table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  // --------------------------------------------------------------------------
  // Result beat
  // --------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_gnd_r, out_other_r, out_recv_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a slot can only be pending while it is valid
  a_pend_in_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~valid_r) == '0)
    else $error("pending mark on an empty slot");

  // the pair walk keeps i below k
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAIR_RD || state_r == ST_PAIR_CMP ||
     state_r == ST_EV_IK || state_r == ST_EV_KI) |-> (i_r < k_r))
    else $error("pair walk out of order");

  // freeing clears every pending mark
  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FREE) |=> (pend_r == '0))
    else $error("pending marks survive the free step");

  // only event beats run without tlast
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_kind_r == KIND_EVENT) != out_last_r))
    else $error("tlast does not match the beat kind");

endmodule
